/* rtl/eapg_pkg.sv */
// ----------------------------------------------------------------------------
// eapg_pkg
// Shared constants, widths and the CORDIC arctangent table for the elliptical
// arc point generator.
// ----------------------------------------------------------------------------
`default_nettype none

package eapg_pkg;

	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 18;

	localparam int FRAC_W  = 17;
	localparam int SWEEP_W = ANGLE_BITS + 1;
	localparam int PROD_W  = FRAC_W + SWEEP_W;
	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int RATIO_W = 17;
	localparam int CFG_IDX_W = 3;

	localparam int XY_W   = 34;
	localparam int Z_W    = 33;
	localparam int TRIG_W = XY_W - 6;
	localparam int MR_W   = RATIO_W + 1 + TRIG_W;
	localparam int RS_W   = MR_W - 16;
	localparam int P_W    = RS_W + DIFF_W;
	localparam int S_W    = P_W + 3;
	localparam int R_W    = S_W - 24;

	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
	localparam logic signed [XY_W-1:0] CORDIC_K = XY_W'(652032874);

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAJOR_END_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAJOR_END_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MINOR_RATIO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_END_ANGLE   = 3'd6;

	// arctan(2^-k) on a 2^32 turn
	function automatic logic signed [Z_W-1:0] atan_turn(input int k);
		logic [31:0] v;
		begin
			case (k)
				0: v = 32'd536870912;
				1: v = 32'd316933406;
				2: v = 32'd167458907;
				3: v = 32'd85004756;
				4: v = 32'd42667331;
				5: v = 32'd21354465;
				6: v = 32'd10680862;
				7: v = 32'd5340245;
				8: v = 32'd2670675;
				9: v = 32'd1335343;
				10: v = 32'd667544;
				11: v = 32'd333772;
				12: v = 32'd166886;
				13: v = 32'd83443;
				14: v = 32'd41722;
				15: v = 32'd20861;
				16: v = 32'd10430;
				17: v = 32'd5215;
				18: v = 32'd2608;
				19: v = 32'd1304;
				20: v = 32'd652;
				21: v = 32'd326;
				22: v = 32'd163;
				23: v = 32'd81;
				24: v = 32'd41;
				25: v = 32'd20;
				26: v = 32'd10;
				27: v = 32'd5;
				28: v = 32'd3;
				29: v = 32'd1;
				30: v = 32'd1;
				default: v = 32'd0;
			endcase
			return $signed({1'b0, v});
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/eapg_angle.sv */
// ----------------------------------------------------------------------------
// eapg_angle
// Two stages: fraction times sweep, then start offset, wrap to a 32-bit turn
// and fold into the right half plane.
// ----------------------------------------------------------------------------
`default_nettype none

module eapg_angle (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          vld_in,
	input  wire logic [eapg_pkg::FRAC_W-1:0]   arc_fraction,
	input  wire logic [15:0]                   start_angle,
	input  wire logic [15:0]                   end_angle,
	output logic                               vld_s2,
	output logic signed [eapg_pkg::Z_W-1:0]    z_s2,
	output logic                               flip_s2
);
	import eapg_pkg::*;

	logic [31:0]            st_w, en_w;
	logic [ANGLE_BITS-1:0]  st, ea, diff;
	logic [SWEEP_W-1:0]     sweep;
	logic [FRAC_W-1:0]      t;
	logic                   vld_s1;
	logic [PROD_W-1:0]      prod_s1;
	logic [ANGLE_BITS-1:0]  st_s1;
	logic [PROD_W-1:0]      off;
	logic [ANGLE_BITS-1:0]  ang;
	logic [31:0]            a32;
	logic signed [Z_W-1:0]  z0;
	logic signed [Z_W-1:0]  zf;
	logic                   fl;

	always_comb begin
		st_w  = {16'd0, start_angle};
		en_w  = {16'd0, end_angle};
		st    = st_w[ANGLE_BITS-1:0];
		ea    = en_w[ANGLE_BITS-1:0];
		diff  = ea - st;
		sweep = (diff == '0) ? {1'b1, {ANGLE_BITS{1'b0}}} : {1'b0, diff};
		t     = (arc_fraction > FRAC_ONE) ? FRAC_ONE : arc_fraction;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(t) * PROD_W'(sweep);
			st_s1   <= st;
		end
	end

	always_comb begin
		off = (prod_s1 + PROD_W'(32768)) >> 16;
		ang = st_s1 + off[ANGLE_BITS-1:0];
		a32 = 32'({ang, {(32 - ANGLE_BITS){1'b0}}});
		z0  = $signed({a32[31], a32});
		fl  = 1'b0;
		zf  = z0;
		if (z0 > (Z_W'(1) <<< 30)) begin
			zf = z0 - (Z_W'(1) <<< 31);
			fl = 1'b1;
		end else if (z0 < -(Z_W'(1) <<< 30)) begin
			zf = z0 + (Z_W'(1) <<< 31);
			fl = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2    <= zf;
			flip_s2 <= fl;
		end
	end

endmodule

`default_nettype wire

/* rtl/eapg_cordic.sv */
// ----------------------------------------------------------------------------
// eapg_cordic
// Rotation-mode CORDIC, one iteration per pipeline stage, followed by a
// stage that undoes the fold and rounds to Q3.24.
// ----------------------------------------------------------------------------
`default_nettype none

module eapg_cordic (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          vld_in,
	input  wire logic signed [eapg_pkg::Z_W-1:0] z_in,
	input  wire logic                          flip_in,
	output logic                               vld_out,
	output logic signed [eapg_pkg::TRIG_W-1:0] cos_out,
	output logic signed [eapg_pkg::TRIG_W-1:0] sin_out
);
	import eapg_pkg::*;

	logic signed [XY_W-1:0] x_s [CORDIC_STAGES];
	logic signed [XY_W-1:0] y_s [CORDIC_STAGES];
	logic signed [Z_W-1:0]  z_s [CORDIC_STAGES];
	logic                   f_s [CORDIC_STAGES];
	logic                   v_s [CORDIC_STAGES];

	logic signed [XY_W-1:0] xl, yl, xr, yr;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		logic signed [XY_W-1:0] xi, yi;
		logic signed [Z_W-1:0]  zi;
		logic                   fi, vi;
		if (i == 0) begin : g_first
			assign xi = CORDIC_K;
			assign yi = '0;
			assign zi = z_in;
			assign fi = flip_in;
			assign vi = vld_in;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign fi = f_s[i-1];
			assign vi = v_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				f_s[i] <= fi;
				if (!zi[Z_W-1]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - atan_turn(i);
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + atan_turn(i);
				end
			end
		end
	end

	always_comb begin
		xl = f_s[CORDIC_STAGES-1] ? -x_s[CORDIC_STAGES-1] : x_s[CORDIC_STAGES-1];
		yl = f_s[CORDIC_STAGES-1] ? -y_s[CORDIC_STAGES-1] : y_s[CORDIC_STAGES-1];
		xr = (xl + XY_W'(32)) >>> 6;
		yr = (yl + XY_W'(32)) >>> 6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= v_s[CORDIC_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_out <= xr[TRIG_W-1:0];
			sin_out <= yr[TRIG_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/eapg_combine.sv */
// ----------------------------------------------------------------------------
// eapg_combine
// Scales sine by the axis ratio, multiplies by the major axis vector, adds
// the center, rounds and saturates. Last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eapg_combine (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            vld_in,
	input  wire logic signed [eapg_pkg::TRIG_W-1:0] cos_in,
	input  wire logic signed [eapg_pkg::TRIG_W-1:0] sin_in,
	input  wire logic [eapg_pkg::RATIO_W-1:0]    minor_ratio,
	input  wire logic signed [eapg_pkg::DIFF_W-1:0] dx,
	input  wire logic signed [eapg_pkg::DIFF_W-1:0] dy,
	input  wire logic signed [eapg_pkg::COORD_W-1:0] center_x,
	input  wire logic signed [eapg_pkg::COORD_W-1:0] center_y,
	output logic                                 vld_s3,
	output logic signed [eapg_pkg::COORD_W-1:0]  px_s3,
	output logic signed [eapg_pkg::COORD_W-1:0]  py_s3
);
	import eapg_pkg::*;

	logic signed [MR_W-1:0]   mr;
	logic signed [MR_W-1:0]   mr_rnd;
	logic                     vld_s1, vld_s2;
	logic signed [RS_W-1:0]   rs_s1;
	logic signed [TRIG_W-1:0] c_s1;
	logic signed [P_W-1:0]    cdx_s2, cdy_s2, rdx_s2, rdy_s2;
	logic signed [S_W-1:0]    sx, sy;
	logic signed [R_W-1:0]    rx, ry;
	logic signed [R_W-1:0]    max_v, min_v;

	always_comb begin
		mr     = MR_W'($signed({1'b0, minor_ratio}) * sin_in);
		mr_rnd = (mr + MR_W'(32768)) >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rs_s1  <= mr_rnd[RS_W-1:0];
			c_s1   <= cos_in;
			cdx_s2 <= P_W'(c_s1 * dx);
			cdy_s2 <= P_W'(c_s1 * dy);
			rdx_s2 <= P_W'(rs_s1 * dx);
			rdy_s2 <= P_W'(rs_s1 * dy);
		end
	end

	always_comb begin
		sx = (S_W'(center_x) <<< 24) + S_W'(cdx_s2) - S_W'(rdy_s2) + (S_W'(1) <<< 23);
		sy = (S_W'(center_y) <<< 24) + S_W'(cdy_s2) + S_W'(rdx_s2) + (S_W'(1) <<< 23);
		rx = R_W'(sx >>> 24);
		ry = R_W'(sy >>> 24);
		max_v = R_W'(32'sh7fffffff);
		min_v = -(R_W'(1) <<< (COORD_W - 1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s3 <= (rx > max_v) ? COORD_W'(max_v) :
			         (rx < min_v) ? COORD_W'(min_v) : rx[COORD_W-1:0];
			py_s3 <= (ry > max_v) ? COORD_W'(max_v) :
			         (ry < min_v) ? COORD_W'(min_v) : ry[COORD_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/ellipse_arc_point_generator.sv */
// ----------------------------------------------------------------------------
// ellipse_arc_point_generator
// Point on a rotated elliptical arc for an arc fraction, Q15.16 output.
// ----------------------------------------------------------------------------
// Accepts one arc_fraction word per cycle while in_ready is high and returns
// point_x/point_y after two angle stages, one stage per CORDIC iteration, a
// rounding stage, and three stages of ratio scaling, axis multiplies and
// sum/saturate. The whole pipeline advances together; while out_valid is high
// and out_ready is low it holds and in_ready is low. Registers are written
// through the cfg port, always ready; the user must write them only while no
// word is in flight (not enforced by the block). Unknown indexes are ignored.
`default_nettype none

module ellipse_arc_point_generator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [eapg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [31:0]                         cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [eapg_pkg::FRAC_W-1:0]         arc_fraction,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [eapg_pkg::COORD_W-1:0]      point_x,
	output logic signed [eapg_pkg::COORD_W-1:0]      point_y
);
	import eapg_pkg::*;

	logic signed [COORD_W-1:0] center_x_q, center_y_q, major_end_x_q, major_end_y_q;
	logic [RATIO_W-1:0]        minor_ratio_q;
	logic [15:0]               start_angle_q, end_angle_q;
	logic signed [DIFF_W-1:0]  dx_q, dy_q;

	logic                      en;
	logic                      a_vld;
	logic signed [Z_W-1:0]     a_z;
	logic                      a_flip;
	logic                      c_vld;
	logic signed [TRIG_W-1:0]  c_cos, c_sin;

	assign cfg_ready = 1'b1;
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			major_end_x_q <= 32'sd65536;
			major_end_y_q <= '0;
			minor_ratio_q <= 17'd65536;
			start_angle_q <= '0;
			end_angle_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CENTER_X:    center_x_q    <= cfg_data;
				REG_CENTER_Y:    center_y_q    <= cfg_data;
				REG_MAJOR_END_X: major_end_x_q <= cfg_data;
				REG_MAJOR_END_Y: major_end_y_q <= cfg_data;
				REG_MINOR_RATIO: minor_ratio_q <= cfg_data[RATIO_W-1:0];
				REG_START_ANGLE: start_angle_q <= cfg_data[15:0];
				REG_END_ANGLE:   end_angle_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		dx_q <= DIFF_W'(major_end_x_q) - DIFF_W'(center_x_q);
		dy_q <= DIFF_W'(major_end_y_q) - DIFF_W'(center_y_q);
	end

	eapg_angle u_angle (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.vld_in       (in_valid),
		.arc_fraction (arc_fraction),
		.start_angle  (start_angle_q),
		.end_angle    (end_angle_q),
		.vld_s2       (a_vld),
		.z_s2         (a_z),
		.flip_s2      (a_flip)
	);

	eapg_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (a_vld),
		.z_in    (a_z),
		.flip_in (a_flip),
		.vld_out (c_vld),
		.cos_out (c_cos),
		.sin_out (c_sin)
	);

	eapg_combine u_combine (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.vld_in      (c_vld),
		.cos_in      (c_cos),
		.sin_in      (c_sin),
		.minor_ratio (minor_ratio_q),
		.dx          (dx_q),
		.dy          (dy_q),
		.center_x    (center_x_q),
		.center_y    (center_y_q),
		.vld_s3      (out_valid),
		.px_s3       (point_x),
		.py_s3       (point_y)
	);

endmodule

`default_nettype wire
